@@ src/tie_pkg.sv @@
package tie_pkg;

    localparam int CODE_W = 5;
    localparam int IDX_W  = 15;
    localparam int STEP_W = 2;

    localparam logic KIND_TEXT = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;

    typedef struct packed {
        logic       kind;
        logic [7:0] char_byte;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] trigram_index;
        logic             first_seen;
        logic             last_of_run;
    } out_item_t;

    typedef struct packed {
        logic accept;
        logic rd_en;
        logic set_wr;
        logic step_inc;
        logic finish;
        logic clr_wr;
    } cmd_t;

    typedef struct packed {
        logic is_end;
        logic last_step;
        logic out_free;
        logic clr_done;
    } status_t;

    function automatic logic [CODE_W-1:0] letter_code(input logic [7:0] ch);
        logic [7:0] diff;
        diff = 8'd0;
        if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
            diff = ch - CHAR_LOWER_A + 8'd1;
        end else if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
            diff = ch - CHAR_UPPER_A + 8'd1;
        end
        return diff[CODE_W-1:0];
    endfunction

endpackage

@@ src/trigram_index_extractor_unit.sv @@
// Letter trigram extractor: takes one text byte or end-of-text marker per item and returns
// trigram indices with a first-seen flag from a single-port bitmap of ALPHABET_SIZE^3 bits.
// Each result costs a read, then a set, on that bitmap port, after the item is taken: a
// text byte gives one result or three, end of text gives two, and end of text is followed
// by a clearing pass over all ALPHABET_SIZE^3 bits (19683 at the default size) during
// which s_ready stays low. The same clearing pass runs after reset.
// Results sit in an output register; the unit stalls only when a new result finds it full.
module trigram_index_extractor_unit
    import tie_pkg::*;
#(
    parameter int ALPHABET_SIZE = 27
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    cmd_t    cmd;
    status_t status;

    tie_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tie_datapath #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef SYNTHESIS
    a_port_single: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.rd_en && (cmd.set_wr || cmd.clr_wr)))
        else $error("bitmap read collides with write");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item taken while one is in work");

    a_clear_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.finish && status.is_end) |=> (!s_ready && cmd.clr_wr))
        else $error("no clearing pass after end of text");

    a_last_on_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> (m_valid && m_data.last_of_run))
        else $error("final result of item not flagged");
`endif

endmodule

@@ src/tie_ctrl.sv @@
module tie_ctrl
    import tie_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_CHECK
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (status.clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (status.out_free) begin
                    cmd.set_wr = 1'b1;
                    if (status.last_step) begin
                        cmd.finish = 1'b1;
                        state_next = status.is_end ? ST_CLEAR : ST_IDLE;
                    end else begin
                        cmd.step_inc = 1'b1;
                        state_next   = ST_LOOKUP;
                    end
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ src/tie_datapath.sv @@
module tie_datapath
    import tie_pkg::*;
#(
    parameter int ALPHABET_SIZE = 27
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  in_item_t  s_data,
    input  cmd_t      cmd,
    output status_t   status,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int MAP_DEPTH = ALPHABET_SIZE * ALPHABET_SIZE * ALPHABET_SIZE;
    localparam int ADDR_W    = $clog2(MAP_DEPTH);

    localparam logic [IDX_W-1:0]  MUL_A    = IDX_W'(ALPHABET_SIZE * ALPHABET_SIZE);
    localparam logic [IDX_W-1:0]  MUL_B    = IDX_W'(ALPHABET_SIZE);
    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(MAP_DEPTH - 1);

    in_item_t           item_reg;
    logic [CODE_W-1:0]  older_reg;
    logic [CODE_W-1:0]  newer_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [ADDR_W-1:0]  clr_addr_reg;
    logic               rdata_reg;
    logic               m_valid_reg;
    out_item_t          m_data_reg;

    logic mem [MAP_DEPTH];

    logic [CODE_W-1:0]  new_code;
    logic [CODE_W-1:0]  tri_a;
    logic [CODE_W-1:0]  tri_b;
    logic [CODE_W-1:0]  tri_c;
    logic [IDX_W-1:0]   tri_index;
    logic [STEP_W-1:0]  last_step_num;

    assign new_code = letter_code(item_reg.char_byte);

    always_comb begin
        tri_a = '0;
        tri_b = '0;
        tri_c = '0;
        if (item_reg.kind == KIND_END) begin
            last_step_num = STEP_W'(1);
            case (step_reg)
                STEP_W'(0): begin
                    tri_a = older_reg;
                    tri_b = newer_reg;
                end
                STEP_W'(1): tri_a = newer_reg;
                default: ;
            endcase
        end else begin
            last_step_num = (newer_reg == '0) ? STEP_W'(2) : STEP_W'(0);
            case (step_reg)
                STEP_W'(0): begin
                    tri_a = older_reg;
                    tri_b = newer_reg;
                    tri_c = new_code;
                end
                STEP_W'(1): tri_a = older_reg;
                STEP_W'(2): tri_c = new_code;
                default: ;
            endcase
        end
    end

    assign tri_index = IDX_W'(tri_a) * MUL_A + IDX_W'(tri_b) * MUL_B + IDX_W'(tri_c);

    assign status.is_end    = (item_reg.kind == KIND_END);
    assign status.last_step = (step_reg == last_step_num);
    assign status.out_free  = !m_valid_reg || m_ready;
    assign status.clr_done  = (clr_addr_reg == CLR_LAST);

    // single port: clear sweep, lookup read, or set write
    always_ff @(posedge aclk) begin
        if (cmd.clr_wr) begin
            mem[clr_addr_reg] <= 1'b0;
        end else if (cmd.set_wr) begin
            mem[tri_index[ADDR_W-1:0]] <= 1'b1;
        end else if (cmd.rd_en) begin
            rdata_reg <= mem[tri_index[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_reg <= s_data;
        end
        if (cmd.set_wr) begin
            m_data_reg.trigram_index <= tri_index;
            m_data_reg.first_seen    <= !rdata_reg;
            m_data_reg.last_of_run   <= status.last_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            older_reg    <= '0;
            newer_reg    <= '0;
            step_reg     <= '0;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.accept) begin
                step_reg <= '0;
            end else if (cmd.step_inc) begin
                step_reg <= step_reg + STEP_W'(1);
            end
            if (cmd.finish) begin
                if (item_reg.kind == KIND_END) begin
                    older_reg <= '0;
                    newer_reg <= '0;
                end else begin
                    older_reg <= newer_reg;
                    newer_reg <= new_code;
                end
            end
            if (cmd.clr_wr) begin
                clr_addr_reg <= status.clr_done ? '0 : clr_addr_reg + ADDR_W'(1);
            end
            if (cmd.set_wr) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
